[rtl/wcts_pkg.sv]
`timescale 1ns / 1ps
// Package for the wall column texel stepper: field widths, register indexes,
// sequencer states and default texture sizes. Depends on nothing.
package wcts_pkg;

  // Default texture sizes; the top level takes them as parameters.
  localparam int TEXTURE_WIDTH_DEF  = 64;
  localparam int TEXTURE_HEIGHT_DEF = 64;

  // Field widths.
  localparam int ROW_W   = 12;
  localparam int CUR_W   = 13;
  localparam int COL_W   = 12;
  localparam int TEXID_W = 4;
  localparam int TX_W    = 6;
  localparam int TY_W    = 6;
  localparam int DIR_W   = 18;
  localparam int DIST_W  = 24;
  localparam int LH_W    = 16;
  localparam int LINE_W  = 17;
  localparam int CAM_W   = 24;
  localparam int PITCH_W = 12;
  localparam int SH_W    = 12;
  localparam int STEP_W  = 24;
  localparam int POS_W   = 40;
  localparam int FRAC_W  = 16;
  localparam int SUM_W   = 20;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [SH_W-1:0]   SCREEN_HEIGHT_RST = SH_W'(480);
  localparam logic [STEP_W-1:0] STEP_MAX          = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_HEIGHT = 2'd0,
    REG_VIEW_PITCH    = 2'd1,
    REG_CAMERA_X      = 2'd2,
    REG_CAMERA_Y      = 2'd3
  } wcts_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_PRODUCT
  } wcts_state_e;

  localparam logic OP_SETUP = 1'b0;
  localparam logic OP_TICK  = 1'b1;

endpackage

[rtl/wcts_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the column items and the texel results.
// Depends on wcts_pkg for the field widths.
interface wcts_in_if import wcts_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic                      hit_side;
  logic signed [DIR_W-1:0]   ray_dir_x;
  logic signed [DIR_W-1:0]   ray_dir_y;
  logic        [DIST_W-1:0]  wall_distance;
  logic        [LH_W-1:0]    line_height;
  logic signed [CUR_W-1:0]   start_row;
  logic        [ROW_W-1:0]   end_row;
  logic        [COL_W-1:0]   screen_column;
  logic        [TEXID_W-1:0] texture_id;
  logic signed [LINE_W-1:0]  line_top;
  logic signed [LINE_W-1:0]  line_shift;

  modport source (
    output valid, op, hit_side, ray_dir_x, ray_dir_y, wall_distance, line_height,
           start_row, end_row, screen_column, texture_id, line_top, line_shift,
    input  ready
  );
  modport sink (
    input  valid, op, hit_side, ray_dir_x, ray_dir_y, wall_distance, line_height,
           start_row, end_row, screen_column, texture_id, line_top, line_shift,
    output ready
  );
endinterface

interface wcts_out_if import wcts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   pixel_column;
  logic [ROW_W-1:0]   pixel_row;
  logic [TX_W-1:0]    texel_x;
  logic [TY_W-1:0]    texel_y;
  logic [TEXID_W-1:0] texture_sel;
  logic               last;

  modport source (
    output valid, pixel_column, pixel_row, texel_x, texel_y, texture_sel, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_column, pixel_row, texel_x, texel_y, texture_sel, last,
    output ready
  );
endinterface

[rtl/wcts_divider.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
module wcts_divider #(
  parameter int DVD_W = 23,
  parameter int DVS_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W+1:0] diff;
  logic             ge;

  // Bring down the next dividend bit and try a subtract.
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};
  assign ge    = ~diff[DVS_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

[rtl/wall_column_texel_stepper.sv]
`timescale 1ns / 1ps
// Wall column texel stepper top level. Depends on wcts_pkg, wcts_if and
// wcts_divider.
//
// A set-up transfer (op 0) loads one wall column: it finds the wall hit
// fraction and the texture column, then divides TEXTURE_HEIGHT << 16 by the
// line height in a restoring divider that yields one quotient bit per cycle,
// and finally multiplies the centering offset by that row step to get the
// starting texture position. A set-up occupies the block through its divide
// and product steps, and the input is not ready during that time. A row tick
// (op 1) produces one texel coordinate for the next row of the column, with
// last set on the final row; ticks after the final row produce nothing. Ticks
// run at one per cycle as long as the output side takes them. Results sit in
// an output register, and in the idle state the input takes a new transfer
// whenever that register is empty or being drained in the same cycle.
// Configuration writes are meant for times when the block is idle.
module wall_column_texel_stepper
  import wcts_pkg::*;
#(
  parameter int TEXTURE_WIDTH  = TEXTURE_WIDTH_DEF,
  parameter int TEXTURE_HEIGHT = TEXTURE_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  wcts_in_if.sink               in_if,
  wcts_out_if.source            out_if
);

  // Quotient width of TEXTURE_HEIGHT << 16, and the texel column width.
  localparam int DVD_W = $clog2(TEXTURE_HEIGHT + 1) + 16;
  localparam int EXT_W = (DVD_W > STEP_W) ? DVD_W : STEP_W;
  localparam int TWW   = $clog2(TEXTURE_WIDTH + 1);
  localparam logic [DVD_W-1:0] DIVIDEND = DVD_W'(TEXTURE_HEIGHT) << 16;

  // Configuration registers.
  logic        [SH_W-1:0]    screen_height_q;
  logic signed [PITCH_W-1:0] view_pitch_q;
  logic        [CAM_W-1:0]   camera_x_q;
  logic        [CAM_W-1:0]   camera_y_q;

  // Column state.
  wcts_state_e               state_q, state_d;
  logic        [TX_W-1:0]    column_texel_x_q;
  logic        [STEP_W-1:0]  row_step_q;
  logic        [POS_W-1:0]   texture_position_q;
  logic signed [CUR_W-1:0]   current_row_q;
  logic        [ROW_W-1:0]   stop_row_q;
  logic        [COL_W-1:0]   held_column_q;
  logic        [TEXID_W-1:0] held_texture_q;

  // Set-up operands carried from the accepting cycle.
  logic        [FRAC_W-1:0]  frac_q;
  logic                      mirror_q;
  logic signed [SUM_W-1:0]   sum_q;

  // Output register.
  logic                      out_valid_q, out_valid_d;
  logic        [ROW_W-1:0]   out_row_q;
  logic        [TY_W-1:0]    out_ty_q;
  logic                      out_last_q;

  // Sequencer outputs.
  logic in_ready;
  logic accept;
  logic setup_go;
  logic tick_go;
  logic step_load;
  logic pos_load;

  // Set-up datapath.
  logic signed [DIR_W-1:0]        dir_sel;
  logic signed [DIST_W+DIR_W:0]   hit_prod;
  logic        [CAM_W-1:0]        cam_sel;
  logic        [FRAC_W-1:0]       frac_d;
  logic        [LH_W-1:0]         lh_eff;
  logic signed [SUM_W-1:0]        sum_d;
  logic                           mirror_d;
  logic                           div_done;
  logic        [DVD_W-1:0]        quotient;
  logic        [EXT_W-1:0]        quot_ext;
  logic        [STEP_W-1:0]       step_sat;
  logic signed [SUM_W+STEP_W:0]   pos_prod;
  logic        [FRAC_W+TWW-1:0]   tx_prod;
  logic        [TWW-1:0]          tx_raw;
  logic        [TWW-1:0]          tx_mir;

  // Row tick datapath.
  logic        [CUR_W:0]          cur_inc;
  logic        [CUR_W:0]          cur_inc2;
  logic        [CUR_W:0]          stop_ext;
  logic                           rows_left;
  logic                           round_up;
  logic        [POS_W-17:0]       ty_full;
  logic        [POS_W-17:0]       ty_mask;

  assign accept   = in_if.valid & in_ready;
  assign setup_go = accept & (in_if.op == OP_SETUP);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (setup_go) state_d = ST_DIVIDE;
      ST_DIVIDE:  if (div_done) state_d = ST_PRODUCT;
      ST_PRODUCT: state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = 1'b0;
    step_load = 1'b0;
    pos_load  = 1'b0;
    case (state_q)
      ST_IDLE:    in_ready  = ~out_valid_q | out_if.ready;
      ST_DIVIDE:  step_load = div_done;
      ST_PRODUCT: pos_load  = 1'b1;
      default:    in_ready  = 1'b0;
    endcase
  end

  // Only the fraction of the hit position matters, so bits 31:16 of the
  // distance times direction product are all that is kept.
  assign dir_sel  = in_if.hit_side ? in_if.ray_dir_x : in_if.ray_dir_y;
  assign cam_sel  = in_if.hit_side ? camera_x_q : camera_y_q;
  assign hit_prod = $signed({1'b0, in_if.wall_distance}) * dir_sel;
  assign frac_d   = cam_sel[FRAC_W-1:0] + hit_prod[31:16];

  // Mirror the column for walls seen from the far side.
  assign mirror_d = in_if.hit_side
                  ? in_if.ray_dir_y[DIR_W-1]
                  : (~in_if.ray_dir_x[DIR_W-1] & (|in_if.ray_dir_x));

  // A zero line height counts as one.
  assign lh_eff = (in_if.line_height == '0) ? LH_W'(1) : in_if.line_height;

  // Centering offset in rows; it all wraps at SUM_W bits, which never overflows.
  assign sum_d = SUM_W'(in_if.line_top) + SUM_W'(view_pitch_q)
               - SUM_W'(screen_height_q[SH_W-1:1]) + SUM_W'(in_if.line_height[LH_W-1:1])
               - SUM_W'(in_if.line_shift);

  wcts_divider #(
    .DVD_W (DVD_W),
    .DVS_W (LH_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (setup_go),
    .dividend_i (DIVIDEND),
    .divisor_i  (lh_eff),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Clamp the row step to its 24 bits.
  assign quot_ext = EXT_W'(quotient);
  assign step_sat = (quot_ext > EXT_W'(STEP_MAX)) ? STEP_MAX : quot_ext[STEP_W-1:0];

  // Starting texture position, kept modulo 2^40.
  assign pos_prod = sum_q * $signed({1'b0, row_step_q});

  assign tx_prod = frac_q * (FRAC_W + TWW)'(TEXTURE_WIDTH);
  assign tx_raw  = tx_prod[FRAC_W+TWW-1:FRAC_W];
  assign tx_mir  = mirror_q ? (TWW'(TEXTURE_WIDTH - 1) - tx_raw) : tx_raw;

  // Row tick: emit while the next row lies before the stop row.
  assign cur_inc   = {current_row_q[CUR_W-1], current_row_q} + (CUR_W + 1)'(1);
  assign cur_inc2  = cur_inc + (CUR_W + 1)'(1);
  assign stop_ext  = (CUR_W + 1)'(stop_row_q);
  assign rows_left = $signed(cur_inc) < $signed(stop_ext);
  assign tick_go   = accept & (in_if.op == OP_TICK) & rows_left;

  // The integer part truncates toward zero: a negative position with a
  // nonzero fraction rounds up by one.
  assign round_up = texture_position_q[POS_W-1] & (|texture_position_q[15:0]);
  assign ty_full  = texture_position_q[POS_W-1:16] + (POS_W - 16)'(round_up);
  assign ty_mask  = ty_full & (POS_W - 16)'(TEXTURE_HEIGHT - 1);

  always_comb begin
    out_valid_d = out_valid_q;
    if (tick_go) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= ST_IDLE;
      out_valid_q        <= 1'b0;
      screen_height_q    <= SCREEN_HEIGHT_RST;
      view_pitch_q       <= '0;
      camera_x_q         <= '0;
      camera_y_q         <= '0;
      column_texel_x_q   <= '0;
      row_step_q         <= '0;
      texture_position_q <= '0;
      current_row_q      <= '0;
      stop_row_q         <= '0;
      held_column_q      <= '0;
      held_texture_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i[SH_W-1:0];
          REG_VIEW_PITCH:    view_pitch_q    <= cfg_data_i[PITCH_W-1:0];
          REG_CAMERA_X:      camera_x_q      <= cfg_data_i[CAM_W-1:0];
          REG_CAMERA_Y:      camera_y_q      <= cfg_data_i[CAM_W-1:0];
          default:           camera_y_q      <= camera_y_q;
        endcase
      end
      if (setup_go) begin
        current_row_q  <= in_if.start_row;
        stop_row_q     <= in_if.end_row;
        held_column_q  <= in_if.screen_column;
        held_texture_q <= in_if.texture_id;
      end else if (tick_go) begin
        current_row_q      <= cur_inc[CUR_W-1:0];
        texture_position_q <= texture_position_q + POS_W'(row_step_q);
      end
      if (step_load) begin
        row_step_q <= step_sat;
      end
      if (pos_load) begin
        texture_position_q <= pos_prod[POS_W-1:0];
        column_texel_x_q   <= TX_W'(tx_mir);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (setup_go) begin
      frac_q   <= frac_d;
      mirror_q <= mirror_d;
      sum_q    <= sum_d;
    end
    if (tick_go) begin
      out_row_q  <= cur_inc[ROW_W-1:0];
      out_ty_q   <= TY_W'(ty_mask);
      out_last_q <= ~($signed(cur_inc2) < $signed(stop_ext));
    end
  end

  // Column, texture and texel column stay fixed while rows are pending, since
  // a set-up needs the output side drained or draining before it is taken.
  assign in_if.ready         = in_ready;
  assign out_if.valid        = out_valid_q;
  assign out_if.pixel_column = held_column_q;
  assign out_if.pixel_row    = out_row_q;
  assign out_if.texel_x      = column_texel_x_q;
  assign out_if.texel_y      = out_ty_q;
  assign out_if.texture_sel  = held_texture_q;
  assign out_if.last         = out_last_q;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the wall column texel stepper: a texel tracker class
// predicts every row texel and checks the output stream. Depends on wcts_pkg,
// wcts_if and the wall_column_texel_stepper RTL.
module tb_top;
  import wcts_pkg::*;

  // The clock period is 8 ns. The run is stopped if it goes past this many cycles.
  localparam int CYCLE_LIMIT  = 1_000_000;
  // A set-up keeps the block busy and produces no texel, so the waits before
  // register writes and at the end leave it time to finish.
  localparam int DRAIN_CYCLES = 48;
  localparam int PHASE_ITEMS  = 272;
  localparam int PHASES       = 6;

  // One column item as the sender presents it on the input channel.
  typedef struct {
    logic                      op;
    logic                      hit_side;
    logic signed [DIR_W-1:0]   ray_dir_x;
    logic signed [DIR_W-1:0]   ray_dir_y;
    logic        [DIST_W-1:0]  wall_distance;
    logic        [LH_W-1:0]    line_height;
    logic signed [CUR_W-1:0]   start_row;
    logic        [ROW_W-1:0]   end_row;
    logic        [COL_W-1:0]   screen_column;
    logic        [TEXID_W-1:0] texture_id;
    logic signed [LINE_W-1:0]  line_top;
    logic signed [LINE_W-1:0]  line_shift;
  } column_item_t;

  // One texel coordinate as it leaves the block.
  typedef struct {
    logic [COL_W-1:0]   pixel_column;
    logic [ROW_W-1:0]   pixel_row;
    logic [TX_W-1:0]    texel_x;
    logic [TY_W-1:0]    texel_y;
    logic [TEXID_W-1:0] texture_sel;
    logic               last;
  } texel_t;

  // The tracker keeps its own copy of the registers and of the column state. It
  // works out the texel that every row tick produces and holds those texels in
  // order until the output side delivers them.
  class texel_tracker;
    logic        [SH_W-1:0]    screen_height;
    logic signed [PITCH_W-1:0] view_pitch;
    logic        [CAM_W-1:0]   camera_x;
    logic        [CAM_W-1:0]   camera_y;

    logic        [TX_W-1:0]    col_texel_x;
    logic        [STEP_W-1:0]  row_step;
    logic        [POS_W-1:0]   tex_pos;
    logic signed [CUR_W-1:0]   cur_row;
    logic        [ROW_W-1:0]   stop_row;
    logic        [COL_W-1:0]   held_column;
    logic        [TEXID_W-1:0] held_texture;

    texel_t texels_due[$];
    int     errors;
    int     texels_checked;

    function new();
      screen_height  = SCREEN_HEIGHT_RST;
      view_pitch     = '0;
      camera_x       = '0;
      camera_y       = '0;
      col_texel_x    = '0;
      row_step       = '0;
      tex_pos        = '0;
      cur_row        = '0;
      stop_row       = '0;
      held_column    = '0;
      held_texture   = '0;
      errors         = 0;
      texels_checked = 0;
    endfunction

    function void write_reg(wcts_reg_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_SCREEN_HEIGHT: screen_height = value[SH_W-1:0];
        REG_VIEW_PITCH:    view_pitch    = value[PITCH_W-1:0];
        REG_CAMERA_X:      camera_x      = value[CAM_W-1:0];
        REG_CAMERA_Y:      camera_y      = value[CAM_W-1:0];
        default: ;
      endcase
    endfunction

    // Loads a new column. Rows still pending from the previous column are dropped.
    function void load_column(column_item_t it);
      longint signed   prod;
      longint signed   offset;
      longint unsigned lh;
      longint unsigned step;
      longint unsigned tx;
      logic [CAM_W-1:0]  hit_pos;
      logic [FRAC_W-1:0] frac;
      if (it.hit_side == 1'b0) begin
        prod    = longint'(it.wall_distance) * longint'(it.ray_dir_y);
        hit_pos = camera_y;
      end else begin
        prod    = longint'(it.wall_distance) * longint'(it.ray_dir_x);
        hit_pos = camera_x;
      end
      // Only the fraction of the wall hit position matters.
      frac = hit_pos[FRAC_W-1:0] + prod[2*FRAC_W-1:FRAC_W];
      tx   = (longint'(frac) * TEXTURE_WIDTH_DEF) >> FRAC_W;
      if ((it.hit_side == 1'b0 && it.ray_dir_x > 0) ||
          (it.hit_side == 1'b1 && it.ray_dir_y < 0)) begin
        tx = TEXTURE_WIDTH_DEF - tx - 1;
      end
      col_texel_x = tx[TX_W-1:0];

      // A zero line height is treated as one row.
      lh   = (it.line_height == '0) ? 1 : longint'(it.line_height);
      step = (longint'(TEXTURE_HEIGHT_DEF) << FRAC_W) / lh;
      if (step > longint'(STEP_MAX)) begin
        step = longint'(STEP_MAX);
      end
      row_step = step[STEP_W-1:0];

      offset = longint'(it.line_top) + longint'(view_pitch)
             - longint'(screen_height >> 1) + longint'(lh >> 1)
             - longint'(it.line_shift);
      // The start position wraps at 40 bits and is read as two's complement.
      tex_pos = POS_W'(offset * longint'(step));

      cur_row      = it.start_row;
      stop_row     = it.end_row;
      held_column  = it.screen_column;
      held_texture = it.texture_id;
    endfunction

    // Advances one row. Returns 1 when the tick produces a texel.
    function bit advance_row();
      int             row_now;
      int             stop_now;
      logic [POS_W-1:0] mag;
      logic [POS_W-1:0] whole;
      texel_t         tx;
      row_now  = int'(cur_row);
      stop_now = int'(stop_row);
      if (row_now + 1 >= stop_now) begin
        return 1'b0;
      end
      row_now = row_now + 1;
      cur_row = CUR_W'(row_now);
      // The integer part is truncated toward zero before the mask is applied.
      mag = -tex_pos;
      if (tex_pos[POS_W-1]) begin
        whole = -(mag >> FRAC_W);
      end else begin
        whole = tex_pos >> FRAC_W;
      end
      tex_pos = tex_pos + POS_W'(row_step);

      tx.pixel_column = held_column;
      tx.pixel_row    = row_now[ROW_W-1:0];
      tx.texel_x      = col_texel_x;
      tx.texel_y      = whole[TY_W-1:0] & TY_W'(TEXTURE_HEIGHT_DEF - 1);
      tx.texture_sel  = held_texture;
      tx.last         = (row_now + 1 >= stop_now);
      texels_due.push_back(tx);
      return 1'b1;
    endfunction

    // Notes an accepted input item. Returns 1 when it produces a texel.
    function bit take_item(column_item_t it);
      if (it.op == OP_SETUP) begin
        load_column(it);
        return 1'b0;
      end
      return advance_row();
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_texel(texel_t got);
      texel_t want;
      if (texels_due.size() == 0) begin
        $error("texel for column %0d row %0d arrived with no texel outstanding",
               got.pixel_column, got.pixel_row);
        errors++;
        return;
      end
      want = texels_due.pop_front();
      texels_checked++;
      compare_field("pixel_column", want.pixel_column, got.pixel_column);
      compare_field("pixel_row", want.pixel_row, got.pixel_row);
      compare_field("texel_x", want.texel_x, got.texel_x);
      compare_field("texel_y", want.texel_y, got.texel_y);
      compare_field("texture_sel", want.texture_sel, got.texture_sel);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wcts_in_if  in_bus ();
  wcts_out_if out_bus ();

  wall_column_texel_stepper i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_if       (in_bus),
    .out_if      (out_bus)
  );

  always #4 clk_i = ~clk_i;

  texel_tracker tracker = new();

  int cycle_count  = 0;
  int burst_left   = 0;
  int n_setups     = 0;
  int n_rows       = 0;
  int n_idle_ticks = 0;
  int n_settings   = 1;

  // The whole run is bounded. A hung handshake ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Every output transfer is checked against the oldest outstanding texel. The
  // output is sampled at the rising edge, before the block updates its registers.
  always @(posedge clk_i) begin
    texel_t got;
    if (rst_ni === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got.pixel_column = out_bus.pixel_column;
      got.pixel_row    = out_bus.pixel_row;
      got.texel_x      = out_bus.texel_x;
      got.texel_y      = out_bus.texel_y;
      got.texture_sel  = out_bus.texture_sel;
      got.last         = out_bus.last;
      tracker.check_texel(got);
    end
  end

  // The receiver stalls on a pattern of its own. It keeps each mode for a random
  // span and then picks another: always ready, mostly ready, mostly stalled, or long
  // alternating runs of ready and stall. Ready changes only at the falling edge.
  initial begin : sink_pacing
    int hold;
    int mode;
    int mode_left;
    hold          = 0;
    mode          = 0;
    mode_left     = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (hold > 0) begin
        hold--;
      end else begin
        case (mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= ($urandom_range(0, 3) != 0);
          2: out_bus.ready <= ($urandom_range(0, 3) == 0);
          default: begin
            out_bus.ready <= ~out_bus.ready;
            hold = $urandom_range(0, 24);
          end
        endcase
      end
    end
  end

  // The sender works in bursts. Between bursts it idles for a random gap. A gap
  // may be zero, which gives long stretches without any idling, or long enough
  // to span the whole set-up time of the block.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap = 0;
        4, 5, 6, 7: gap = $urandom_range(1, 4);
        8:          gap = $urandom_range(5, 12);
        default:    gap = $urandom_range(13, 30);
      endcase
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
  endtask

  // Drives one item at the falling edge and holds it until the block takes it.
  // Returns at the next falling edge, so that a following item keeps valid high
  // without lowering it in between.
  task automatic send_item(input column_item_t it);
    pace();
    in_bus.op            <= it.op;
    in_bus.hit_side      <= it.hit_side;
    in_bus.ray_dir_x     <= it.ray_dir_x;
    in_bus.ray_dir_y     <= it.ray_dir_y;
    in_bus.wall_distance <= it.wall_distance;
    in_bus.line_height   <= it.line_height;
    in_bus.start_row     <= it.start_row;
    in_bus.end_row       <= it.end_row;
    in_bus.screen_column <= it.screen_column;
    in_bus.texture_id    <= it.texture_id;
    in_bus.line_top      <= it.line_top;
    in_bus.line_shift    <= it.line_shift;
    in_bus.valid         <= 1'b1;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    if (tracker.take_item(it)) begin
      n_rows++;
    end else if (it.op == OP_SETUP) begin
      n_setups++;
    end else begin
      n_idle_ticks++;
    end
    @(negedge clk_i);
  endtask

  // Waits until every outstanding texel has arrived and the block has had time
  // to finish a set-up that produces nothing.
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (tracker.texels_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Writes all four registers on consecutive cycles while the block is idle.
  task automatic program_regs(input logic [SH_W-1:0] sh, input logic [PITCH_W-1:0] pitch,
                              input logic [CAM_W-1:0] cam_x, input logic [CAM_W-1:0] cam_y);
    logic [CFG_DATA_W-1:0] vals [4];
    vals[REG_SCREEN_HEIGHT] = CFG_DATA_W'(sh);
    vals[REG_VIEW_PITCH]    = CFG_DATA_W'(pitch);
    vals[REG_CAMERA_X]      = CFG_DATA_W'(cam_x);
    vals[REG_CAMERA_Y]      = CFG_DATA_W'(cam_y);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      tracker.write_reg(wcts_reg_e'(i), vals[i]);
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Fills every field at random. Row ticks ignore everything but op, so they get
  // random content too.
  function automatic column_item_t random_fields(logic op);
    column_item_t it;
    it.op            = op;
    it.hit_side      = 1'($urandom_range(0, 1));
    it.ray_dir_x     = DIR_W'($urandom);
    it.ray_dir_y     = DIR_W'($urandom);
    it.wall_distance = ($urandom_range(0, 3) == 0) ? DIST_W'($urandom_range(0, 1023))
                                                   : DIST_W'($urandom);
    case ($urandom_range(0, 19))
      0:                      it.line_height = '0;
      1, 2, 3, 4, 5, 6, 7, 8: it.line_height = LH_W'($urandom_range(1, 1000));
      default:                it.line_height = LH_W'($urandom);
    endcase
    it.start_row     = CUR_W'($urandom);
    it.end_row       = ROW_W'($urandom);
    it.screen_column = COL_W'($urandom);
    it.texture_id    = TEXID_W'($urandom);
    it.line_top      = ($urandom_range(0, 1) == 0) ? LINE_W'($urandom)
                                                   : LINE_W'($urandom_range(0, 2000) - 1000);
    it.line_shift    = ($urandom_range(0, 1) == 0) ? LINE_W'($urandom)
                                                   : LINE_W'($urandom_range(0, 200) - 100);
    return it;
  endfunction

  // A set-up that draws exactly the given number of rows, placed anywhere on the
  // screen, with the lowest and highest placements picked now and then.
  function automatic column_item_t column_with_rows(int rows);
    column_item_t it;
    int           first;
    it = random_fields(OP_SETUP);
    case ($urandom_range(0, 9))
      0:       first = -1;
      1:       first = 4094 - rows;
      default: first = int'($urandom_range(0, 4095 - rows)) - 1;
    endcase
    it.start_row = CUR_W'(first);
    it.end_row   = ROW_W'(first + rows + 1);
    return it;
  endfunction

  task automatic send_ticks(int count);
    repeat (count) send_item(random_fields(OP_TICK));
  endtask

  task automatic run_directed();
    column_item_t it;
    // A tick right after reset finds no rows pending.
    send_ticks(1);

    // Zero line height with the largest line top and the most negative line shift.
    // Side 0 with a positive x direction mirrors the texture column.
    it               = random_fields(OP_SETUP);
    it.hit_side      = 1'b0;
    it.ray_dir_x     = 18'sd131071;
    it.ray_dir_y     = 18'sd131071;
    it.wall_distance = '1;
    it.line_height   = '0;
    it.start_row     = -13'sd1;
    it.end_row       = 12'd3;
    it.screen_column = '1;
    it.texture_id    = '1;
    it.line_top      = 17'sd65535;
    it.line_shift    = -17'sd65536;
    send_item(it);
    send_ticks(3);

    // Side 1 with a negative y direction mirrors; rows run up to the top row.
    it               = random_fields(OP_SETUP);
    it.hit_side      = 1'b1;
    it.ray_dir_x     = -18'sd131072;
    it.ray_dir_y     = -18'sd131072;
    it.wall_distance = '0;
    it.line_height   = '1;
    it.start_row     = 13'sd4090;
    it.end_row       = 12'd4095;
    it.screen_column = '0;
    it.texture_id    = '0;
    it.line_top      = -17'sd65536;
    it.line_shift    = 17'sd65535;
    send_item(it);
    send_ticks(4);

    // Rows below zero wrap the pixel row around the top of the screen.
    it               = random_fields(OP_SETUP);
    it.hit_side      = 1'b0;
    it.ray_dir_x     = -18'sd5000;
    it.ray_dir_y     = -18'sd131072;
    it.wall_distance = 24'h012345;
    it.line_height   = 16'd1;
    it.start_row     = -13'sd3;
    it.end_row       = 12'd2;
    it.line_top      = '0;
    it.line_shift    = '0;
    send_item(it);
    send_ticks(4);

    // A new set-up in the middle of a column drops the rows still pending.
    it               = random_fields(OP_SETUP);
    it.hit_side      = 1'b1;
    it.ray_dir_y     = 18'sd70000;
    it.line_height   = 16'd64;
    it.start_row     = 13'sd10;
    it.end_row       = 12'd20;
    send_item(it);
    send_ticks(1);
    it               = random_fields(OP_SETUP);
    it.line_height   = 16'd32767;
    it.start_row     = 13'sd100;
    it.end_row       = 12'd103;
    send_item(it);
    send_ticks(2);
  endtask

  // Mostly whole columns with random content; the rest are columns cut short by
  // the next set-up, extra ticks past the last row, columns with no rows at all
  // and stray ticks.
  task automatic run_random(int target);
    column_item_t it;
    int           base;
    int           rows;
    int           kind;
    base = n_setups + n_rows;
    while (n_setups + n_rows - base < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        rows = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        send_item(column_with_rows(rows));
        case ($urandom_range(0, 9))
          0, 1:    send_ticks($urandom_range(0, rows - 1));
          2, 3:    send_ticks(rows + $urandom_range(1, 3));
          default: send_ticks(rows);
        endcase
      end else if (kind < 90) begin
        it           = random_fields(OP_SETUP);
        it.end_row   = ROW_W'($urandom);
        it.start_row = CUR_W'(int'($urandom_range(it.end_row, 4095)) - 1);
        send_item(it);
        send_ticks($urandom_range(0, 2));
      end else begin
        send_ticks($urandom_range(1, 3));
      end
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    in_bus.valid         = 1'b0;
    in_bus.op            = OP_TICK;
    in_bus.hit_side      = 1'b0;
    in_bus.ray_dir_x     = '0;
    in_bus.ray_dir_y     = '0;
    in_bus.wall_distance = '0;
    in_bus.line_height   = '0;
    in_bus.start_row     = '0;
    in_bus.end_row       = '0;
    in_bus.screen_column = '0;
    in_bus.texture_id    = '0;
    in_bus.line_top      = '0;
    in_bus.line_shift    = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // The directed items run with the register values from reset.
    run_directed();

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: program_regs(12'd1, 12'h800, '0, '1);
        1: program_regs(12'd4095, 12'h7FF, '1, '0);
        5: program_regs(SCREEN_HEIGHT_RST, '0, CAM_W'($urandom), CAM_W'($urandom));
        default: program_regs(SH_W'($urandom_range(1, 4095)), PITCH_W'($urandom),
                              CAM_W'($urandom), CAM_W'($urandom));
      endcase
      run_random(PHASE_ITEMS);
    end
    settle();

    $display("Run covered %0d column set-ups, %0d drawn rows and %0d idle ticks",
             n_setups, n_rows, n_idle_ticks);
    $display("under %0d settings; %0d texels checked, %0d mismatches.",
             n_settings, tracker.texels_checked, tracker.errors);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
